@@ sv/prc_pkg.sv @@
package prc_pkg;

  // Number of clip stages in the cascade.
  localparam int unsigned NSTAGE = 4;

  // Depth of the vertex queue between the front and the back.
  localparam int unsigned QDEPTH = 4;

  // Stage codes, in the order the polygon passes through them.
  localparam logic [1:0] STG_LEFT  = 2'd0;
  localparam logic [1:0] STG_RIGHT = 2'd1;
  localparam logic [1:0] STG_LOWER = 2'd2;
  localparam logic [1:0] STG_UPPER = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_LEFT  = 2'd0;
  localparam logic [1:0] REG_RIGHT = 2'd1;
  localparam logic [1:0] REG_UPPER = 2'd2;
  localparam logic [1:0] REG_LOWER = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_EMIT,
    ST_SINK,
    ST_NEXT,
    ST_FIN
  } eng_state_e;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_state_e;

  // Handshake between the front queue and the back engine.
  typedef struct packed {
    logic valid;
    logic last;
  } q_status_t;

endpackage

@@ sv/polygon_rect_clipper_core.sv @@
// Rectangle polygon clipper. Vertices of a polygon arrive one request at a
// time, the last one flagged by final_vertex_i; the polygon is clipped against
// the left, right, lower and upper boundaries in turn, a vertex counting as
// inside only when strictly within a bound, and the clipped vertices leave one
// request at a time, the last one flagged by final_clipped_o. A polygon that
// vanishes entirely yields a single request with polygon_empty_o set and zero
// coordinates. Input vertices enter a four-deep queue, so the source is only
// held off when four vertices are waiting. The back end walks each edge
// through the four stages in turn on a shared sequencer: an edge is
// evaluated and emitted, with a division step between when it crosses a
// boundary, where the intersection is found by one multiply followed by a
// bit-serial divider that retires one quotient bit per cycle. The polygon
// end adds the four closing edges. Clip boundaries are written through the
// cfg port; the user must write them only while the block is idle, which
// the block itself does not enforce, and they take effect at once.
module polygon_rect_clipper_core
  import prc_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [COORD_BITS-1:0]        cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] vertex_x_i,
  input  logic signed [COORD_BITS-1:0] vertex_y_i,
  input  logic                         final_vertex_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [COORD_BITS-1:0] clipped_x_o,
  output logic signed [COORD_BITS-1:0] clipped_y_o,
  output logic                         final_clipped_o,
  output logic                         polygon_empty_o
);

  q_status_t                    q_status;
  logic signed [COORD_BITS-1:0] q_x, q_y;
  logic                         q_pop;
  logic                         md_start, md_done;
  logic signed [COORD_BITS:0]   md_a, md_b, md_d;
  logic signed [COORD_BITS+1:0] md_q;

  // Front: accepts vertex requests and buffers them for the sequencer.
  prc_queue #(.COORD_BITS(COORD_BITS)) u_queue (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .vertex_x_i     (vertex_x_i),
    .vertex_y_i     (vertex_y_i),
    .final_vertex_i (final_vertex_i),
    .pop_i          (q_pop),
    .status_o       (q_status),
    .x_o            (q_x),
    .y_o            (q_y)
  );

  // Shared intersection unit: exact product, quotient truncated toward zero.
  prc_muldiv #(.COORD_BITS(COORD_BITS)) u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .a_i     (md_a),
    .b_i     (md_b),
    .d_i     (md_d),
    .done_o  (md_done),
    .q_o     (md_q)
  );

  // Back: per-stage edge state, the cascade sequencer and the output register.
  prc_engine #(.COORD_BITS(COORD_BITS)) u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .q_status_i      (q_status),
    .q_x_i           (q_x),
    .q_y_i           (q_y),
    .q_pop_o         (q_pop),
    .md_start_o      (md_start),
    .md_a_o          (md_a),
    .md_b_o          (md_b),
    .md_d_o          (md_d),
    .md_done_i       (md_done),
    .md_q_i          (md_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .clipped_x_o     (clipped_x_o),
    .clipped_y_o     (clipped_y_o),
    .final_clipped_o (final_clipped_o),
    .polygon_empty_o (polygon_empty_o)
  );

endmodule

@@ sv/prc_queue.sv @@
module prc_queue
  import prc_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] vertex_x_i,
  input  logic signed [COORD_BITS-1:0] vertex_y_i,
  input  logic                         final_vertex_i,
  input  logic                         pop_i,
  output q_status_t                    status_o,
  output logic signed [COORD_BITS-1:0] x_o,
  output logic signed [COORD_BITS-1:0] y_o
);

  localparam int unsigned PW = $clog2(QDEPTH);
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  logic signed [COORD_BITS-1:0] mem_x_q [QDEPTH];
  logic signed [COORD_BITS-1:0] mem_y_q [QDEPTH];
  logic                         mem_l_q [QDEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic push, pop;

  assign in_stall_o = (cnt_q == CW'(QDEPTH));
  assign push = in_valid_i && !in_stall_o;
  assign pop  = pop_i && (cnt_q != '0);

  assign status_o.valid = (cnt_q != '0);
  assign status_o.last  = mem_l_q[rd_q];
  assign x_o = mem_x_q[rd_q];
  assign y_o = mem_y_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= PW'(wr_q + 1'b1);
      if (pop)  rd_q <= PW'(rd_q + 1'b1);
      if (push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_x_q[wr_q] <= vertex_x_i;
      mem_y_q[wr_q] <= vertex_y_i;
      mem_l_q[wr_q] <= final_vertex_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(QDEPTH))
    else $error("vertex queue fill exceeds its depth");
`endif

endmodule

@@ sv/prc_muldiv.sv @@
module prc_muldiv
  import prc_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic signed [COORD_BITS:0] a_i,
  input  logic signed [COORD_BITS:0] b_i,
  input  logic signed [COORD_BITS:0] d_i,
  output logic                       done_o,
  output logic signed [COORD_BITS+1:0] q_o
);

  localparam int unsigned W  = COORD_BITS + 1;
  localparam int unsigned CW = $clog2(W + 1);

  md_state_e st_q, st_d;
  logic [W-1:0] ma_q, mb_q, md_q, rem_q, lo_q;
  logic [2*W-1:0] prod;
  logic [W:0] trial;
  logic ge;
  logic [CW-1:0] cnt_q;
  logic neg_q, done_q;

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
    mag = v[W-1] ? W'(-v) : W'(v);
  endfunction

  assign prod  = ma_q * mb_q;
  assign trial = {rem_q, lo_q[W-1]};
  assign ge    = (trial >= {1'b0, md_q});

  always_comb begin
    st_d = st_q;
    case (st_q)
      MD_IDLE: if (start_i) st_d = MD_MUL;
      MD_MUL:  st_d = MD_DIV;
      MD_DIV:  if (cnt_q == CW'(1)) st_d = MD_IDLE;
      default: st_d = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= MD_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= (st_q == MD_DIV) && (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      MD_IDLE: begin
        if (start_i) begin
          ma_q  <= mag(a_i);
          mb_q  <= mag(b_i);
          md_q  <= mag(d_i);
          neg_q <= a_i[W-1] ^ b_i[W-1] ^ d_i[W-1];
        end
      end
      MD_MUL: begin
        // The quotient is known to fit in W bits, so the high half is
        // already below the divisor.
        rem_q <= prod[2*W-1:W];
        lo_q  <= prod[W-1:0];
        cnt_q <= CW'(W);
      end
      MD_DIV: begin
        rem_q <= ge ? W'(trial - {1'b0, md_q}) : W'(trial);
        lo_q  <= {lo_q[W-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign q_o = neg_q ? -$signed({1'b0, lo_q}) : $signed({1'b0, lo_q});

endmodule

@@ sv/prc_engine.sv @@
module prc_engine
  import prc_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [COORD_BITS-1:0]        cfg_data_i,
  input  q_status_t                    q_status_i,
  input  logic signed [COORD_BITS-1:0] q_x_i,
  input  logic signed [COORD_BITS-1:0] q_y_i,
  output logic                         q_pop_o,
  output logic                         md_start_o,
  output logic signed [COORD_BITS:0]   md_a_o,
  output logic signed [COORD_BITS:0]   md_b_o,
  output logic signed [COORD_BITS:0]   md_d_o,
  input  logic                         md_done_i,
  input  logic signed [COORD_BITS+1:0] md_q_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [COORD_BITS-1:0] clipped_x_o,
  output logic signed [COORD_BITS-1:0] clipped_y_o,
  output logic                         final_clipped_o,
  output logic                         polygon_empty_o
);

  localparam int unsigned N = COORD_BITS;
  localparam int unsigned SPW = $clog2(NSTAGE + 1);

  eng_state_e st_q, st_d;

  logic signed [N-1:0] left_q, right_q, upper_q, lower_q;
  logic signed [N-1:0] first_x_q [NSTAGE];
  logic signed [N-1:0] first_y_q [NSTAGE];
  logic signed [N-1:0] prev_x_q  [NSTAGE];
  logic signed [N-1:0] prev_y_q  [NSTAGE];
  logic [NSTAGE-1:0]   started_q;

  logic [1:0]          tok_s_q;
  logic signed [N-1:0] tok_x_q, tok_y_q;
  logic                tok_close_q, end_q;
  logic [SPW-1:0]      cls_q;

  logic [1:0]          stk_s_q [NSTAGE];
  logic signed [N-1:0] stk_x_q [NSTAGE];
  logic signed [N-1:0] stk_y_q [NSTAGE];
  logic [SPW-1:0]      sp_q, sp_m1;

  logic signed [N-1:0] b_x_q, b_y_q, p_x_q, p_y_q, ob_q, bnd_q;
  logic                inside_q, cross_q, more_q;
  logic signed [N-1:0] sink_x_q, sink_y_q, held_x_q, held_y_q;
  logic                held_v_q;

  logic                out_v_q, out_fin_q, out_emp_q;
  logic signed [N-1:0] out_x_q, out_y_q;

  // Current edge, from the stage's previous vertex to the token's vertex, or to the stage's first vertex when closing.
  logic                axis_y, keep_gt, edge_ok, is_in, crosses;
  logic signed [N-1:0] bnd, ex, ey, ca, cb, oa, ob;
  logic signed [N+1:0] p_o;
  logic                can_push, sink_go, out_load, has_out, top_stage;

  assign axis_y  = tok_s_q[1];
  assign keep_gt = (tok_s_q == STG_LEFT) || (tok_s_q == STG_UPPER);
  assign edge_ok = started_q[tok_s_q];
  assign ex = tok_close_q ? first_x_q[tok_s_q] : tok_x_q;
  assign ey = tok_close_q ? first_y_q[tok_s_q] : tok_y_q;
  assign ca = axis_y ? prev_y_q[tok_s_q] : prev_x_q[tok_s_q];
  assign oa = axis_y ? prev_x_q[tok_s_q] : prev_y_q[tok_s_q];
  assign cb = axis_y ? ey : ex;
  assign ob = axis_y ? ex : ey;

  always_comb begin
    case (tok_s_q)
      STG_LEFT:  bnd = left_q;
      STG_RIGHT: bnd = right_q;
      STG_LOWER: bnd = lower_q;
      default:   bnd = upper_q;
    endcase
  end

  assign is_in   = keep_gt ? (cb > bnd) : (cb < bnd);
  assign crosses = ((ca < bnd) && (bnd < cb)) || ((cb < bnd) && (bnd < ca));

  assign md_start_o = (st_q == ST_EVAL) && edge_ok && crosses;
  assign md_a_o = $signed({ob[N-1], ob}) - $signed({oa[N-1], oa});
  assign md_b_o = $signed({cb[N-1], cb}) - $signed({bnd[N-1], bnd});
  assign md_d_o = $signed({cb[N-1], cb}) - $signed({ca[N-1], ca});
  assign p_o    = $signed({{2{ob_q[N-1]}}, ob_q}) - md_q_i;

  assign q_pop_o   = (st_q == ST_IDLE) && q_status_i.valid;
  assign can_push  = !out_v_q || !out_stall_i;
  assign sink_go   = !held_v_q || can_push;
  assign has_out   = cross_q || inside_q;
  assign top_stage = (tok_s_q == STG_UPPER);
  assign sp_m1     = sp_q - 1'b1;
  assign out_load  = ((st_q == ST_SINK) && sink_go && held_v_q) ||
                     ((st_q == ST_FIN) && can_push);

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: if (q_status_i.valid) st_d = ST_EVAL;
      ST_EVAL: begin
        if (!edge_ok) st_d = ST_NEXT;
        else if (crosses) st_d = ST_DIV;
        else st_d = ST_EMIT;
      end
      ST_DIV:  if (md_done_i) st_d = ST_EMIT;
      ST_EMIT: begin
        if (!has_out) st_d = ST_NEXT;
        else if (top_stage) st_d = ST_SINK;
        else st_d = ST_EVAL;
      end
      ST_SINK: if (sink_go && !more_q) st_d = ST_NEXT;
      ST_NEXT: begin
        if (sp_q != '0) st_d = ST_EVAL;
        else if (end_q && (cls_q != SPW'(NSTAGE))) st_d = ST_EVAL;
        else if (end_q) st_d = ST_FIN;
        else st_d = ST_IDLE;
      end
      ST_FIN:  if (can_push) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      left_q      <= '0;
      right_q     <= '0;
      upper_q     <= '0;
      lower_q     <= '0;
      started_q   <= '0;
      tok_s_q     <= STG_LEFT;
      tok_close_q <= 1'b0;
      end_q       <= 1'b0;
      cls_q       <= '0;
      sp_q        <= '0;
      more_q      <= 1'b0;
      held_v_q    <= 1'b0;
      out_v_q     <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_LEFT:  left_q  <= cfg_data_i;
          REG_RIGHT: right_q <= cfg_data_i;
          REG_UPPER: upper_q <= cfg_data_i;
          default:   lower_q <= cfg_data_i;
        endcase
      end
      if (out_load) out_v_q <= 1'b1;
      else if (!out_stall_i) out_v_q <= 1'b0;
      case (st_q)
        ST_IDLE: begin
          if (q_status_i.valid) begin
            tok_s_q     <= STG_LEFT;
            tok_close_q <= 1'b0;
            end_q       <= q_status_i.last;
            cls_q       <= '0;
          end
        end
        ST_EVAL: begin
          if (edge_ok && tok_close_q) started_q[tok_s_q] <= 1'b0;
          else if (!edge_ok && !tok_close_q) started_q[tok_s_q] <= 1'b1;
        end
        ST_EMIT: begin
          if (top_stage) begin
            more_q <= cross_q && inside_q;
          end else if (has_out) begin
            tok_s_q     <= tok_s_q + 2'd1;
            tok_close_q <= 1'b0;
            if (cross_q && inside_q) sp_q <= sp_q + 1'b1;
          end
        end
        ST_SINK: begin
          if (sink_go) begin
            held_v_q <= 1'b1;
            more_q   <= 1'b0;
          end
        end
        ST_NEXT: begin
          if (sp_q != '0) begin
            sp_q        <= sp_m1;
            tok_s_q     <= stk_s_q[sp_m1[1:0]];
            tok_close_q <= 1'b0;
          end else if (end_q && (cls_q != SPW'(NSTAGE))) begin
            tok_s_q     <= cls_q[1:0];
            tok_close_q <= 1'b1;
            cls_q       <= cls_q + 1'b1;
          end
        end
        ST_FIN: begin
          if (can_push) begin
            held_v_q <= 1'b0;
            end_q    <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (st_q == ST_FIN) begin
        out_x_q   <= held_v_q ? held_x_q : '0;
        out_y_q   <= held_v_q ? held_y_q : '0;
        out_fin_q <= 1'b1;
        out_emp_q <= !held_v_q;
      end else begin
        out_x_q   <= held_x_q;
        out_y_q   <= held_y_q;
        out_fin_q <= 1'b0;
        out_emp_q <= 1'b0;
      end
    end
    case (st_q)
      ST_IDLE: begin
        tok_x_q <= q_x_i;
        tok_y_q <= q_y_i;
      end
      ST_EVAL: begin
        b_x_q    <= ex;
        b_y_q    <= ey;
        inside_q <= is_in;
        cross_q  <= crosses;
        ob_q     <= ob;
        bnd_q    <= bnd;
        if (!tok_close_q) begin
          prev_x_q[tok_s_q] <= ex;
          prev_y_q[tok_s_q] <= ey;
          if (!edge_ok) begin
            first_x_q[tok_s_q] <= ex;
            first_y_q[tok_s_q] <= ey;
          end
        end
      end
      ST_DIV: begin
        if (md_done_i) begin
          p_x_q <= axis_y ? p_o[N-1:0] : bnd_q;
          p_y_q <= axis_y ? bnd_q : p_o[N-1:0];
        end
      end
      ST_EMIT: begin
        if (top_stage) begin
          sink_x_q <= cross_q ? p_x_q : b_x_q;
          sink_y_q <= cross_q ? p_y_q : b_y_q;
        end else begin
          tok_x_q <= cross_q ? p_x_q : b_x_q;
          tok_y_q <= cross_q ? p_y_q : b_y_q;
          if (cross_q && inside_q) begin
            stk_s_q[sp_q[1:0]] <= tok_s_q + 2'd1;
            stk_x_q[sp_q[1:0]] <= b_x_q;
            stk_y_q[sp_q[1:0]] <= b_y_q;
          end
        end
      end
      ST_SINK: begin
        if (sink_go) begin
          held_x_q <= sink_x_q;
          held_y_q <= sink_y_q;
          sink_x_q <= b_x_q;
          sink_y_q <= b_y_q;
        end
      end
      ST_NEXT: begin
        if (sp_q != '0) begin
          tok_x_q <= stk_x_q[sp_m1[1:0]];
          tok_y_q <= stk_y_q[sp_m1[1:0]];
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o     = out_v_q;
  assign clipped_x_o     = out_x_q;
  assign clipped_y_o     = out_y_q;
  assign final_clipped_o = out_fin_q;
  assign polygon_empty_o = out_emp_q;

`ifndef SYNTHESIS
  a_div_cross: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DIV) && md_done_i |-> cross_q)
    else $error("divider result arrived for an edge without a crossing");
  a_idle_stack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_IDLE) |-> (sp_q == '0) && (started_q == '0 || !end_q))
    else $error("pending stack entries while waiting for a vertex");
  a_fin_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_FIN) |-> end_q && (cls_q == SPW'(NSTAGE)) && (started_q == '0))
    else $error("polygon finished before every stage was closed");
`endif

endmodule

@@ tb/polygon_rect_clipper_core_tb.sv @@
`timescale 1ns / 1ps

module polygon_rect_clipper_core_tb;
  import prc_pkg::*;

  localparam int CW = 16;
  localparam int STALL_LIMIT = 40000;
  localparam int SETTLE_CYCLES = 400;

  typedef struct {
    longint x;
    longint y;
  } pt_t;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 fin;
    logic                 empty;
  } clip_out_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [1:0]           cfg_idx_i = REG_LEFT;
  logic [CW-1:0]        cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic signed [CW-1:0] vertex_x_i = '0;
  logic signed [CW-1:0] vertex_y_i = '0;
  logic                 final_vertex_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic signed [CW-1:0] clipped_x_o;
  logic signed [CW-1:0] clipped_y_o;
  logic                 final_clipped_o;
  logic                 polygon_empty_o;

  always #5 clk_i = ~clk_i;

  polygon_rect_clipper_core #(.COORD_BITS(CW)) u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .vertex_x_i, .vertex_y_i, .final_vertex_i,
    .out_valid_o, .out_stall_i, .clipped_x_o, .clipped_y_o,
    .final_clipped_o, .polygon_empty_o
  );

  // Copy of the clipper state kept by the testbench.
  longint bound_left, bound_right, bound_upper, bound_lower;
  pt_t    stage_first[NSTAGE];
  pt_t    stage_prev[NSTAGE];
  bit     stage_seen[NSTAGE];
  bit     held_valid;
  pt_t    held_pt;

  // Clipped vertices still owed by the block, oldest first.
  clip_out_t pending_clip_q[$];

  int  errors = 0;
  int  vertices_sent = 0;
  int  polygons_sent = 0;
  int  results_seen = 0;
  bit  idling_on = 1'b1;
  int  quiet_cycles = 0;

  function automatic longint stage_bound(int s);
    case (s)
      STG_LEFT:  return bound_left;
      STG_RIGHT: return bound_right;
      STG_LOWER: return bound_lower;
      default:   return bound_upper;
    endcase
  endfunction

  // One edge a->b through stage s: the crossing first, then the end vertex.
  task automatic clip_one_edge(input int s, input pt_t a, input pt_t b, ref pt_t lst[$]);
    longint bnd, ca, cb, oa, ob, lo, hi, o;
    bit     on_y, keep;
    pt_t    p;
    bnd  = stage_bound(s);
    on_y = (s == STG_LOWER || s == STG_UPPER);
    ca = on_y ? a.y : a.x;
    cb = on_y ? b.y : b.x;
    oa = on_y ? a.x : a.y;
    ob = on_y ? b.x : b.y;
    lo = (ca < cb) ? ca : cb;
    hi = (ca < cb) ? cb : ca;
    keep = (s == STG_LEFT || s == STG_UPPER) ? (cb > bnd) : (cb < bnd);
    if (lo < bnd && bnd < hi) begin
      // SystemVerilog division truncates toward zero, as required.
      o = ob - ((ob - oa) * (cb - bnd)) / (cb - ca);
      p.x = on_y ? o : bnd;
      p.y = on_y ? bnd : o;
      lst.push_back(p);
    end
    if (keep) lst.push_back(b);
  endtask

  task automatic predict_vertex(input longint vx, input longint vy, input bit fin);
    pt_t       cur[$];
    pt_t       nxt[$];
    pt_t       v;
    clip_out_t r;
    v.x = vx;
    v.y = vy;
    cur.push_back(v);
    for (int s = 0; s < NSTAGE; s++) begin
      nxt.delete();
      foreach (cur[i]) begin
        if (stage_seen[s]) begin
          clip_one_edge(s, stage_prev[s], cur[i], nxt);
        end else begin
          stage_first[s] = cur[i];
          stage_seen[s]  = 1'b1;
        end
        stage_prev[s] = cur[i];
      end
      if (fin && stage_seen[s]) begin
        clip_one_edge(s, stage_prev[s], stage_first[s], nxt);
        stage_seen[s] = 1'b0;
      end
      cur = nxt;
    end
    // The last surviving vertex is held back so it can carry the final flag.
    foreach (cur[i]) begin
      if (held_valid) begin
        r.x = held_pt.x[CW-1:0];
        r.y = held_pt.y[CW-1:0];
        r.fin = 1'b0;
        r.empty = 1'b0;
        pending_clip_q.push_back(r);
      end
      held_pt = cur[i];
      held_valid = 1'b1;
    end
    if (fin) begin
      r.x = held_valid ? held_pt.x[CW-1:0] : '0;
      r.y = held_valid ? held_pt.y[CW-1:0] : '0;
      r.fin = 1'b1;
      r.empty = !held_valid;
      pending_clip_q.push_back(r);
      held_valid = 1'b0;
      held_pt.x = 0;
      held_pt.y = 0;
    end
  endtask

  // Sends one vertex request and waits for it to be taken; may leave a gap after.
  task automatic send_vertex(input logic signed [CW-1:0] vx, input logic signed [CW-1:0] vy,
                             input bit fin);
    predict_vertex(vx, vy, fin);
    in_valid_i     <= 1'b1;
    vertex_x_i     <= vx;
    vertex_y_i     <= vy;
    final_vertex_i <= fin;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    vertices_sent++;
    if (fin) polygons_sent++;
    if (idling_on && $urandom_range(99) < 7) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Holds the source back until the block has delivered everything owed.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_clip_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_bound(input logic [1:0] idx, input logic signed [CW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      REG_LEFT:  bound_left  = val;
      REG_RIGHT: bound_right = val;
      REG_UPPER: bound_upper = val;
      default:   bound_lower = val;
    endcase
  endtask

  task automatic set_rect(input int l, input int r, input int u, input int d);
    wait_drained();
    write_bound(REG_LEFT, l);
    write_bound(REG_RIGHT, r);
    write_bound(REG_UPPER, u);
    write_bound(REG_LOWER, d);
  endtask

  // Hand-picked polygons: whole inside, crossing every side, lone vertices,
  // empty result, edges lying on the boundary and the extremes of the range.
  task automatic test_directed();
    set_rect(-100, 100, -100, 100);
    send_vertex(-10, -10, 0); send_vertex(10, -10, 0); send_vertex(0, 10, 1);
    send_vertex(-300, 0, 0); send_vertex(0, -300, 0); send_vertex(300, 20, 0);
    send_vertex(7, 300, 1);
    send_vertex(5, 5, 1);
    send_vertex(100, 5, 1);
    send_vertex(200, 200, 0); send_vertex(300, 250, 0); send_vertex(250, 400, 1);
    send_vertex(-100, -50, 0); send_vertex(-100, 50, 0); send_vertex(50, 100, 1);
    set_rect(-32768, 32767, -32768, 32767);
    send_vertex(-32768, -32768, 0); send_vertex(32767, 0, 0);
    send_vertex(-1, 32767, 1);
    send_vertex(0, 0, 0); send_vertex(-32767, 32766, 1);
    set_rect(32767, -32768, 32767, -32768);
    send_vertex(-32768, 32767, 0); send_vertex(32767, -32768, 1);
  endtask

  function automatic logic signed [CW-1:0] pick_coord(input int lo_b, input int hi_b);
    int span;
    if ($urandom_range(19) == 0) return $urandom();
    span = hi_b - lo_b + 40;
    return lo_b - 20 + $signed($urandom_range(span));
  endfunction

  // Random rectangles with random polygons around them; mostly small, a few
  // with coordinates over the whole range.
  task automatic test_random(input int n_vertices);
    int l, r, u, d, cnt, k;
    cnt = 0;
    while (cnt < n_vertices) begin
      if ($urandom_range(5) == 0) begin
        l = $urandom_range(200) - 100;
        r = l + $urandom_range(1, 200);
        u = $urandom_range(200) - 100;
        d = u + $urandom_range(1, 200);
        if ($urandom_range(15) == 0) begin
          l = -32768 + $urandom_range(3);
          r = 32767 - $urandom_range(3);
        end
        set_rect(l, r, u, d);
      end
      k = ($urandom_range(7) == 0) ? 1 : $urandom_range(2, 8);
      for (int i = 0; i < k; i++) begin
        send_vertex(pick_coord(bound_left, bound_right), pick_coord(bound_upper, bound_lower),
                    i == k - 1);
      end
      cnt += k;
    end
  endtask

  initial begin
    bound_left = 0; bound_right = 0; bound_upper = 0; bound_lower = 0;
    held_valid = 0;
    foreach (stage_seen[i]) stage_seen[i] = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    idling_on = 1'b0;
    test_random(60);
    idling_on = 1'b1;
    test_random(330);
    wait_drained();
    $display("Covered %0d vertices in %0d polygons, %0d clipped vertices checked.",
             vertices_sent, polygons_sent, results_seen);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Result checker; it also stalls the output at random outside quiet stretches.
  always @(posedge clk_i) begin
    clip_out_t e;
    out_stall_i <= idling_on && ($urandom_range(99) < 7);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_clip_q.size() == 0) begin
        $display("%0t: unexpected request x=%0d y=%0d", $time, clipped_x_o, clipped_y_o);
        errors++;
      end else begin
        e = pending_clip_q.pop_front();
        if (clipped_x_o !== e.x || clipped_y_o !== e.y || final_clipped_o !== e.fin ||
            polygon_empty_o !== e.empty) begin
          $display("%0t: expected x=%0d y=%0d fin=%0b empty=%0b, got x=%0d y=%0d fin=%0b empty=%0b",
                   $time, e.x, e.y, e.fin, e.empty, clipped_x_o, clipped_y_o,
                   final_clipped_o, polygon_empty_o);
          errors++;
        end
      end
    end
  end

  // Watchdog: too long with neither side moving ends the run.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni ||
        (pending_clip_q.size() == 0 && !in_valid_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

@@ filelist.f @@
sv/prc_pkg.sv
sv/prc_queue.sv
sv/prc_muldiv.sv
sv/prc_engine.sv
sv/polygon_rect_clipper_core.sv
tb/polygon_rect_clipper_core_tb.sv
